// ----- rtl/ivs_pkg.sv -----
// Shared constants, register indexes and types for the integral volume stream.
// No dependencies; integral_volume_stream and ivs_pos refer to it by scoped names.
`timescale 1ns / 1ps

package ivs_pkg;

    localparam int MAX_X  = 64;
    localparam int MAX_Y  = 64;
    localparam int MAX_Z  = 1024;

    localparam int X_W    = (MAX_X > 1) ? $clog2(MAX_X) : 1;
    localparam int Y_W    = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
    localparam int Z_W    = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
    // plane store address is {y, x}
    localparam int CELL_W = X_W + Y_W;

    localparam int DATA_W = 32;
    localparam int SX_W   = 7;
    localparam int SY_W   = 7;
    localparam int SZ_W   = 11;
    localparam int CFG_W  = 11;
    localparam int IDX_W  = 2;

    localparam logic [IDX_W-1:0] REG_SIZE_X = 2'd0;
    localparam logic [IDX_W-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [IDX_W-1:0] REG_SIZE_Z = 2'd2;

    // position of the word being accepted, and its edge flags
    typedef struct packed {
        logic [X_W-1:0]    x;
        logic [CELL_W-1:0] plane_addr;
        logic              first_x;
        logic              first_y;
        logic              first_z;
        logic              last;
    } t_pos;

    // size register value -> last index, zero acting as one, overflow as the maximum
    function automatic logic [CFG_W-1:0] clamp_last(input logic [CFG_W-1:0] v,
                                                    input int unsigned      maxv);
        logic [CFG_W-1:0] r;
        if (v == '0)
            r = '0;
        else if (v > CFG_W'(maxv))
            r = CFG_W'(maxv - 1);
        else
            r = v - CFG_W'(1);
        return r;
    endfunction

endpackage

// ----- rtl/integral_volume_stream.sv -----
// Top level of the streaming integral volume: position counters, line and plane
// stores, accumulate stage and output register. Depends on ivs_pkg, ivs_pos, ivs_ram.
`timescale 1ns / 1ps

// Usage:
//   Input words (i_voxel_value) arrive in raster order, x fastest, then y, then z,
//   on i_in_valid / o_in_stall. Each accepted word gives one output word on
//   o_out_valid / i_out_stall: the 3D inclusive prefix sum modulo 2^32, with
//   o_volume_end high on the final voxel of the volume.
//   Sizes are written on i_cfg_we / i_cfg_idx / i_cfg_data (0: size_x, 1: size_y,
//   2: size_z) while the block is idle; any such write restarts the volume.
//   Words pass the accumulate stage and the output register to o_out_valid, one
//   word per cycle while the receiver does not stall. The stores are read at
//   acceptance and written back by the accumulate stage, a write that meets a
//   read of the same entry being forwarded. On a receiver stall the output register
//   and accumulate stage each hold a word; o_in_stall rises only with both full.
//   Reset (synchronous, active low) empties the pipeline and sets sizes 64 x 64 x 1.
//   The stores are not cleared; each volume writes every entry before reading it.
module integral_volume_stream (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [ivs_pkg::IDX_W-1:0]  i_cfg_idx,
    input  logic [ivs_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [ivs_pkg::DATA_W-1:0] i_voxel_value,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [ivs_pkg::DATA_W-1:0] o_prefix_sum,
    output logic                       o_volume_end
);

    ivs_pkg::t_pos               pos;
    logic                        in_acc, s1_move, out_free;

    logic                        r_s1_valid, n_s1_valid;
    ivs_pkg::t_pos               r_s1_pos;
    logic [ivs_pkg::DATA_W-1:0]  r_s1_value;
    logic                        r_fwd_line, r_fwd_plane;
    logic [ivs_pkg::DATA_W-1:0]  r_fwd_line_d, r_fwd_plane_d;
    logic [ivs_pkg::DATA_W-1:0]  r_row;

    logic                        r_out_valid, n_out_valid;
    logic [ivs_pkg::DATA_W-1:0]  r_out_sum;
    logic                        r_out_end;

    logic [ivs_pkg::DATA_W-1:0]  line_rd, plane_rd, line_q, plane_q;
    logic [ivs_pkg::DATA_W-1:0]  row_sum, plane_sum, vol_sum;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_move    = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    ivs_pos u_pos (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_advance  (in_acc),
        .o_pos      (pos)
    );

    ivs_ram #(
        .WIDTH (ivs_pkg::DATA_W),
        .DEPTH (ivs_pkg::MAX_X),
        .AW    (ivs_pkg::X_W)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (s1_move),
        .i_waddr (r_s1_pos.x),
        .i_wdata (plane_sum),
        .i_re    (in_acc),
        .i_raddr (pos.x),
        .o_rdata (line_rd)
    );

    ivs_ram #(
        .WIDTH (ivs_pkg::DATA_W),
        .DEPTH (ivs_pkg::MAX_X * ivs_pkg::MAX_Y),
        .AW    (ivs_pkg::CELL_W)
    ) u_plane_store (
        .i_clk   (i_clk),
        .i_we    (s1_move),
        .i_waddr (r_s1_pos.plane_addr),
        .i_wdata (vol_sum),
        .i_re    (in_acc),
        .i_raddr (pos.plane_addr),
        .o_rdata (plane_rd)
    );

    // the RAM returns old data when the write-back hits the entry being read
    assign line_q    = r_fwd_line  ? r_fwd_line_d  : line_rd;
    assign plane_q   = r_fwd_plane ? r_fwd_plane_d : plane_rd;

    assign row_sum   = r_s1_pos.first_x ? r_s1_value : r_row + r_s1_value;
    assign plane_sum = r_s1_pos.first_y ? row_sum : line_q + row_sum;
    assign vol_sum   = r_s1_pos.first_z ? plane_sum : plane_q + plane_sum;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_acc)
            n_s1_valid = 1'b1;
        else if (s1_move)
            n_s1_valid = 1'b0;
        n_out_valid = r_out_valid;
        if (s1_move)
            n_out_valid = 1'b1;
        else if (!i_out_stall)
            n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fwd_line  <= 1'b0;
            r_fwd_plane <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
            if (in_acc) begin
                r_fwd_line  <= s1_move && (r_s1_pos.x == pos.x);
                r_fwd_plane <= s1_move && (r_s1_pos.plane_addr == pos.plane_addr);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pos      <= pos;
            r_s1_value    <= i_voxel_value;
            r_fwd_line_d  <= plane_sum;
            r_fwd_plane_d <= vol_sum;
        end
        if (s1_move) begin
            r_row     <= row_sum;
            r_out_sum <= vol_sum;
            r_out_end <= r_s1_pos.last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_prefix_sum = r_out_sum;
    assign o_volume_end = r_out_end;

endmodule

// ----- rtl/ivs_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Read during write at the same address returns the old contents.
`timescale 1ns / 1ps

module ivs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/ivs_pos.sv -----
// Size registers and raster position counters (x, y, z and plane store address).
// Depends on ivs_pkg.
`timescale 1ns / 1ps

module ivs_pos (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [ivs_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [ivs_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                      i_advance,
    output ivs_pkg::t_pos             o_pos
);

    logic [ivs_pkg::X_W-1:0]    r_last_x, n_last_x;
    logic [ivs_pkg::Y_W-1:0]    r_last_y, n_last_y;
    logic [ivs_pkg::Z_W-1:0]    r_last_z, n_last_z;
    logic [ivs_pkg::X_W-1:0]    r_x, n_x;
    logic [ivs_pkg::Y_W-1:0]    r_y, n_y;
    logic [ivs_pkg::Z_W-1:0]    r_z, n_z;

    logic [ivs_pkg::CFG_W-1:0]  cl_x, cl_y, cl_z;
    logic                       end_x, end_y, end_z;

    assign cl_x = ivs_pkg::clamp_last(
        ivs_pkg::CFG_W'(i_cfg_data[ivs_pkg::SX_W-1:0]), ivs_pkg::MAX_X);
    assign cl_y = ivs_pkg::clamp_last(
        ivs_pkg::CFG_W'(i_cfg_data[ivs_pkg::SY_W-1:0]), ivs_pkg::MAX_Y);
    assign cl_z = ivs_pkg::clamp_last(
        ivs_pkg::CFG_W'(i_cfg_data[ivs_pkg::SZ_W-1:0]), ivs_pkg::MAX_Z);

    assign end_x = (r_x == r_last_x);
    assign end_y = (r_y == r_last_y);
    assign end_z = (r_z == r_last_z);

    always_comb begin
        n_last_x = r_last_x;
        n_last_y = r_last_y;
        n_last_z = r_last_z;
        n_x      = r_x;
        n_y      = r_y;
        n_z      = r_z;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                ivs_pkg::REG_SIZE_X: n_last_x = cl_x[ivs_pkg::X_W-1:0];
                ivs_pkg::REG_SIZE_Y: n_last_y = cl_y[ivs_pkg::Y_W-1:0];
                ivs_pkg::REG_SIZE_Z: n_last_z = cl_z[ivs_pkg::Z_W-1:0];
                default: ;
            endcase
            // a listed register restarts the volume
            if (i_cfg_idx == ivs_pkg::REG_SIZE_X || i_cfg_idx == ivs_pkg::REG_SIZE_Y ||
                i_cfg_idx == ivs_pkg::REG_SIZE_Z) begin
                n_x = '0;
                n_y = '0;
                n_z = '0;
            end
        end else if (i_advance) begin
            if (!end_x) begin
                n_x = r_x + ivs_pkg::X_W'(1);
            end else begin
                n_x = '0;
                if (!end_y) begin
                    n_y = r_y + ivs_pkg::Y_W'(1);
                end else begin
                    n_y = '0;
                    n_z = end_z ? '0 : r_z + ivs_pkg::Z_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_x <= ivs_pkg::X_W'(ivs_pkg::MAX_X - 1);
            r_last_y <= ivs_pkg::Y_W'(ivs_pkg::MAX_Y - 1);
            r_last_z <= '0;
            r_x      <= '0;
            r_y      <= '0;
            r_z      <= '0;
        end else begin
            r_last_x <= n_last_x;
            r_last_y <= n_last_y;
            r_last_z <= n_last_z;
            r_x      <= n_x;
            r_y      <= n_y;
            r_z      <= n_z;
        end
    end

    assign o_pos.x          = r_x;
    assign o_pos.plane_addr = {r_y, r_x};
    assign o_pos.first_x    = (r_x == '0);
    assign o_pos.first_y    = (r_y == '0);
    assign o_pos.first_z    = (r_z == '0);
    assign o_pos.last       = end_x && end_y && end_z;

endmodule
